@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

`define ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define ASSERT_CLK(lbl, prop, msg)

`define ASSERT_RST(lbl, prop, msg)

`endif

`endif

@@ rtl/h2r_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package h2r_pkg;

    typedef enum logic [2:0] {
        SEC_RED     = 3'd0,
        SEC_YELLOW  = 3'd1,
        SEC_GREEN   = 3'd2,
        SEC_CYAN    = 3'd3,
        SEC_BLUE    = 3'd4,
        SEC_MAGENTA = 3'd5
    } t_sector;

    localparam logic [7:0]  LEVEL_MAX    = 8'd255;
    localparam logic [15:0] DIV255_MAGIC = 16'h8081;
    localparam int          DIV255_SHIFT = 23;

    // one-step fixup of the reciprocal estimate of y/255
    function automatic logic [7:0] div255_fix(input logic [15:0] y, input logic [7:0] e);
        logic [15:0] rem;
        rem = y - ({e, 8'h00} - {8'h00, e});
        return (rem >= {8'h00, LEVEL_MAX}) ? e + 8'd1 : e;
    endfunction

endpackage

`default_nettype wire

@@ rtl/hsv_to_rgb_converter.sv @@
// HSV to RGB color converter, fully pipelined.
// Input channel: i_valid / o_ready carry one request of i_hue (fraction of a
// turn, HUE_BITS wide), i_saturation and i_brightness (both level/255).
// Output channel: o_valid / i_ready carry o_red_out, o_green_out, o_blue_out.
// There are six register stages (sector split, products, numerators, level
// scaling, reciprocal divide by 255, fixup and channel select), the first
// loaded at the accepting edge.
// Throughput: one request per cycle while i_ready is high; every stage can load each cycle.
// Stall: each stage holds while the one after it is full and stalled, and a
// stage with an empty slot keeps loading, so bubbles close up. o_ready drops
// only once all six stages hold data and i_ready is low.
// Reset: synchronous active-low i_rst_n clears all valid bits; the block
// comes out of reset empty and ready.
`timescale 1ns / 1ps
`default_nettype none

module hsv_to_rgb_converter #(
    parameter int HUE_BITS = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire [HUE_BITS-1:0]  i_hue,
    input  wire [7:0]           i_saturation,
    input  wire [7:0]           i_brightness,
    output logic                o_valid,
    input  wire                 i_ready,
    output logic [7:0]          o_red_out,
    output logic [7:0]          o_green_out,
    output logic [7:0]          o_blue_out
);

    `include "assert_macros.svh"

    localparam int NST   = 6;
    localparam int NUM_W = HUE_BITS + 8;
    localparam logic [NUM_W-1:0]  FULL_DEN = {8'hFF, {HUE_BITS{1'b0}}};
    localparam logic [HUE_BITS:0] HUE_ONE  = {1'b1, {HUE_BITS{1'b0}}};

    logic [NST-1:0] r_vld;
    logic [NST-1:0] n_vld;
    logic [NST:0]   w_open;

    always_comb begin
        w_open[NST] = i_ready;
        for (int k = NST - 1; k >= 0; k--) begin
            w_open[k] = !r_vld[k] || w_open[k+1];
        end
        for (int k = 0; k < NST; k++) begin
            if (w_open[k]) begin
                n_vld[k] = (k == 0) ? i_valid : r_vld[(k == 0) ? 0 : k - 1];
            end else begin
                n_vld[k] = r_vld[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_ready = w_open[0];
    assign o_valid = r_vld[NST-1];

    // stage 0: sector and fraction
    logic [HUE_BITS+2:0] w_h6;
    h2r_pkg::t_sector    r0_sec;
    logic [HUE_BITS-1:0] r0_f;
    logic [7:0]          r0_s, r0_v;

    assign w_h6 = (HUE_BITS+3)'({i_hue, 2'b00}) + (HUE_BITS+3)'({i_hue, 1'b0});

    always_ff @(posedge i_clk) begin
        if (w_open[0]) begin
            r0_sec <= h2r_pkg::t_sector'(w_h6[HUE_BITS+2:HUE_BITS]);
            r0_f   <= w_h6[HUE_BITS-1:0];
            r0_s   <= i_saturation;
            r0_v   <= i_brightness;
        end
    end

    // stage 1: f*s, (1-f)*s, v*(255-s)
    logic [HUE_BITS:0]   w_g;
    logic [NUM_W-1:0]    w_gs;
    logic [NUM_W-1:0]    w_fs;
    h2r_pkg::t_sector    r1_sec;
    logic [7:0]          r1_v;
    logic [NUM_W-1:0]    r1_fs, r1_gs;
    logic [15:0]         r1_pv;

    assign w_g  = HUE_ONE - {1'b0, r0_f};
    assign w_gs = NUM_W'(w_g) * NUM_W'(r0_s);
    assign w_fs = NUM_W'(r0_f) * NUM_W'(r0_s);

    always_ff @(posedge i_clk) begin
        if (w_open[1]) begin
            r1_sec <= r0_sec;
            r1_v   <= r0_v;
            r1_fs  <= w_fs;
            r1_gs  <= w_gs;
            r1_pv  <= 16'(r0_v) * 16'(h2r_pkg::LEVEL_MAX - r0_s);
        end
    end

    // stage 2: numerators
    h2r_pkg::t_sector r2_sec;
    logic [7:0]       r2_v;
    logic [NUM_W-1:0] r2_nq, r2_nt;
    logic [15:0]      r2_pv;

    always_ff @(posedge i_clk) begin
        if (w_open[2]) begin
            r2_sec <= r1_sec;
            r2_v   <= r1_v;
            r2_nq  <= FULL_DEN - r1_fs;
            r2_nt  <= FULL_DEN - r1_gs;
            r2_pv  <= r1_pv;
        end
    end

    // stage 3: scale by v, drop the hue fraction bits
    logic [HUE_BITS+15:0] w_vq, w_vt;
    h2r_pkg::t_sector     r3_sec;
    logic [7:0]           r3_v;
    logic [15:0]          r3_yq, r3_yt, r3_yp;

    assign w_vq = (HUE_BITS+16)'(r2_v) * (HUE_BITS+16)'(r2_nq);
    assign w_vt = (HUE_BITS+16)'(r2_v) * (HUE_BITS+16)'(r2_nt);

    always_ff @(posedge i_clk) begin
        if (w_open[3]) begin
            r3_sec <= r2_sec;
            r3_v   <= r2_v;
            r3_yq  <= w_vq[HUE_BITS+15:HUE_BITS];
            r3_yt  <= w_vt[HUE_BITS+15:HUE_BITS];
            r3_yp  <= r2_pv;
        end
    end

    // stage 4: reciprocal estimate of y/255
    logic [31:0]      w_mq, w_mt, w_mp;
    h2r_pkg::t_sector r4_sec;
    logic [7:0]       r4_v;
    logic [15:0]      r4_yq, r4_yt, r4_yp;
    logic [7:0]       r4_eq, r4_et, r4_ep;

    assign w_mq = 32'(r3_yq) * 32'(h2r_pkg::DIV255_MAGIC);
    assign w_mt = 32'(r3_yt) * 32'(h2r_pkg::DIV255_MAGIC);
    assign w_mp = 32'(r3_yp) * 32'(h2r_pkg::DIV255_MAGIC);

    always_ff @(posedge i_clk) begin
        if (w_open[4]) begin
            r4_sec <= r3_sec;
            r4_v   <= r3_v;
            r4_yq  <= r3_yq;
            r4_yt  <= r3_yt;
            r4_yp  <= r3_yp;
            r4_eq  <= 8'(w_mq >> h2r_pkg::DIV255_SHIFT);
            r4_et  <= 8'(w_mt >> h2r_pkg::DIV255_SHIFT);
            r4_ep  <= 8'(w_mp >> h2r_pkg::DIV255_SHIFT);
        end
    end

    // stage 5: fixup and channel select
    logic [7:0] w_q, w_t, w_p;
    logic [7:0] n_red, n_green, n_blue;
    logic [7:0] r5_red, r5_green, r5_blue;
    logic       w_est_ok;

    assign w_q = h2r_pkg::div255_fix(r4_yq, r4_eq);
    assign w_t = h2r_pkg::div255_fix(r4_yt, r4_et);
    assign w_p = h2r_pkg::div255_fix(r4_yp, r4_ep);

    assign w_est_ok = (r4_eq <= r4_v) && (r4_et <= r4_v) && (r4_ep <= r4_v);

    always_comb begin
        unique case (r4_sec)
            h2r_pkg::SEC_RED: begin
                n_red = r4_v; n_green = w_t;  n_blue = w_p;
            end
            h2r_pkg::SEC_YELLOW: begin
                n_red = w_q;  n_green = r4_v; n_blue = w_p;
            end
            h2r_pkg::SEC_GREEN: begin
                n_red = w_p;  n_green = r4_v; n_blue = w_t;
            end
            h2r_pkg::SEC_CYAN: begin
                n_red = w_p;  n_green = w_q;  n_blue = r4_v;
            end
            h2r_pkg::SEC_BLUE: begin
                n_red = w_t;  n_green = w_p;  n_blue = r4_v;
            end
            default: begin
                n_red = r4_v; n_green = w_p;  n_blue = w_q;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_open[5]) begin
            r5_red   <= n_red;
            r5_green <= n_green;
            r5_blue  <= n_blue;
        end
    end

    assign o_red_out   = r5_red;
    assign o_green_out = r5_green;
    assign o_blue_out  = r5_blue;

    `ASSERT_RST(a_empty_after_reset, $past(!i_rst_n) |-> !o_valid, "valid after reset")
    `ASSERT_CLK(a_take_lands, (i_valid && o_ready) |=> r_vld[0], "request lost at stage 0")
    `ASSERT_CLK(a_est_le_v, r_vld[4] |-> w_est_ok, "quotient estimate above level")
    `ASSERT_CLK(a_full_stall, (&r_vld && !i_ready) |-> !o_ready, "request taken when full")

endmodule

`default_nettype wire
